// ===== rtl/core/stok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg - source tokenizer shared definitions
// Payload structs, token and scan codes, and character class helpers.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int TEXT_BYTES          = 8;
    localparam int TEXT_W              = 8 * TEXT_BYTES;
    localparam int LEN_W               = 4;
    localparam int MAX_TOKEN_CHARS_DEF = 8;

    typedef enum logic [2:0] {
        KIND_IDENT    = 3'd0,
        KIND_NUMBER   = 3'd1,
        KIND_OPERATOR = 3'd2,
        KIND_KEYWORD  = 3'd3,
        KIND_PUNCT    = 3'd4,
        KIND_END      = 3'd5
    } t_token_kind;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } t_scan_mode;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_src_op;

    typedef struct packed {
        logic       op;
        logic [7:0] source_byte;
    } t_src_in;

    typedef struct packed {
        t_token_kind        token_kind;
        logic [TEXT_W-1:0]  token_text;
        logic [LEN_W-1:0]   token_length;
        logic               truncated;
        logic               last_of_item;
    } t_token_out;

    // keyword texts, first character in the lowest byte
    localparam logic [TEXT_W-1:0] KW_INT_TEXT    = 64'h0000_0000_0074_6E69;
    localparam logic [TEXT_W-1:0] KW_RETURN_TEXT = 64'h0000_6E72_7574_6572;
    localparam logic [LEN_W-1:0]  KW_INT_LEN     = 4'd3;
    localparam logic [LEN_W-1:0]  KW_RETURN_LEN  = 4'd6;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // + - * /
    function automatic logic is_operator(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F;
    endfunction

    // { } ( ) ;
    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h7B || c == 8'h7D || c == 8'h28 || c == 8'h29 || c == 8'h3B;
    endfunction

endpackage

// ===== rtl/core/source_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer - byte-serial lexical analyzer
// Scans source text one byte per transfer and emits identifier, number,
// keyword, operator, punctuator and end tokens.
// ----------------------------------------------------------------------------
// Throughput: one source byte per cycle while the token channel does not stall.
// A byte that ends a pending token and is itself an operator or punctuator,
// and an end-of-source item that flushes a pending token, produce two tokens;
// the second waits in a spill register behind the output register, and the
// input is held until it drains. The first token is registered in the output
// register in the cycle after the input transfer. Tokens longer than
// MAX_TOKEN_CHARS keep their first characters and flag truncation.
module source_tokenizer #(
    parameter int MAX_TOKEN_CHARS = stok_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // source byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stok_pkg::t_src_in    i_in_data,
    // token channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stok_pkg::t_token_out o_out_data
);

    localparam logic [stok_pkg::LEN_W-1:0] LEN_MAX = stok_pkg::LEN_W'(MAX_TOKEN_CHARS);

    // scanner state
    stok_pkg::t_scan_mode             r_mode, n_mode;
    logic [stok_pkg::TEXT_W-1:0]      r_text, n_text;
    logic [stok_pkg::LEN_W-1:0]       r_len,  n_len;
    logic                             r_ovf,  n_ovf;

    // output register and spill stage
    stok_pkg::t_token_out             r_out,  n_out;
    logic                             r_out_v, n_out_v;
    stok_pkg::t_token_out             r_spill, n_spill;
    logic                             r_spill_v, n_spill_v;

    // tokens produced by the current transfer
    stok_pkg::t_token_out             res0, res1;
    logic [1:0]                       res_cnt;

    logic                             accept;
    logic                             pop;
    logic [7:0]                       c;
    logic                             pend_active;
    stok_pkg::t_token_out             flush_tok;

    // Hold the input while a second token waits, or while the output
    // register is full and not being drained.
    assign o_in_stall  = r_spill_v | (r_out_v & i_out_stall);
    assign accept      = i_in_valid & ~o_in_stall;
    assign pop         = r_out_v & ~i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign c = i_in_data.source_byte;
    assign pend_active = (r_mode == stok_pkg::MODE_IDENT) ||
                         (r_mode == stok_pkg::MODE_NUMBER);

    // Pending token as it would be flushed; keywords only when not truncated.
    always_comb begin
        flush_tok              = '0;
        flush_tok.token_kind   = (r_mode == stok_pkg::MODE_IDENT) ? stok_pkg::KIND_IDENT
                                                                  : stok_pkg::KIND_NUMBER;
        flush_tok.token_text   = r_text;
        flush_tok.token_length = r_len;
        flush_tok.truncated    = r_ovf;
        if (r_mode == stok_pkg::MODE_IDENT && !r_ovf &&
            ((r_len == stok_pkg::KW_INT_LEN    && r_text == stok_pkg::KW_INT_TEXT) ||
             (r_len == stok_pkg::KW_RETURN_LEN && r_text == stok_pkg::KW_RETURN_TEXT))) begin
            flush_tok.token_kind = stok_pkg::KIND_KEYWORD;
        end
    end

    // Next scanner state for an accepted transfer.
    always_comb begin
        n_mode = r_mode;
        n_text = r_text;
        n_len  = r_len;
        n_ovf  = r_ovf;
        if (accept) begin
            if (i_in_data.op == stok_pkg::OP_END) begin
                n_mode = stok_pkg::MODE_IDLE;
                n_text = '0;
                n_len  = '0;
                n_ovf  = 1'b0;
            end else if ((r_mode == stok_pkg::MODE_IDENT &&
                          (stok_pkg::is_letter(c) || stok_pkg::is_digit(c))) ||
                         (r_mode == stok_pkg::MODE_NUMBER && stok_pkg::is_digit(c))) begin
                // extend the pending token, or mark overflow when full
                if (r_len < LEN_MAX) begin
                    for (int b = 0; b < stok_pkg::TEXT_BYTES; b++) begin
                        if (r_len == stok_pkg::LEN_W'(b)) begin
                            n_text[8*b +: 8] = c;
                        end
                    end
                    n_len = r_len + stok_pkg::LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                // end the pending token; a letter or digit starts a new one
                n_text = '0;
                n_len  = '0;
                n_ovf  = 1'b0;
                n_mode = stok_pkg::MODE_IDLE;
                if (stok_pkg::is_letter(c)) begin
                    n_mode      = stok_pkg::MODE_IDENT;
                    n_text[7:0] = c;
                    n_len       = stok_pkg::LEN_W'(1);
                end else if (stok_pkg::is_digit(c)) begin
                    n_mode      = stok_pkg::MODE_NUMBER;
                    n_text[7:0] = c;
                    n_len       = stok_pkg::LEN_W'(1);
                end
            end
        end
    end

    // Tokens for the current transfer, in order, with the last one flagged.
    always_comb begin
        stok_pkg::t_token_out single;
        logic                 has_single;
        single     = '0;
        has_single = 1'b0;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;
        if (i_in_data.op == stok_pkg::OP_END) begin
            single.token_kind = stok_pkg::KIND_END;
            has_single        = 1'b1;
        end else if (stok_pkg::is_operator(c) || stok_pkg::is_punct(c)) begin
            single.token_kind   = stok_pkg::is_operator(c) ? stok_pkg::KIND_OPERATOR
                                                           : stok_pkg::KIND_PUNCT;
            single.token_text   = {{(stok_pkg::TEXT_W-8){1'b0}}, c};
            single.token_length = stok_pkg::LEN_W'(1);
            has_single          = 1'b1;
        end
        single.last_of_item = 1'b1;

        // a byte that extends the pending token flushes nothing
        if (i_in_data.op == stok_pkg::OP_BYTE &&
            ((r_mode == stok_pkg::MODE_IDENT &&
              (stok_pkg::is_letter(c) || stok_pkg::is_digit(c))) ||
             (r_mode == stok_pkg::MODE_NUMBER && stok_pkg::is_digit(c)))) begin
            res_cnt = 2'd0;
        end else if (pend_active) begin
            res0 = flush_tok;
            if (has_single) begin
                res1    = single;
                res_cnt = 2'd2;
            end else begin
                res0.last_of_item = 1'b1;
                res_cnt           = 2'd1;
            end
        end else if (has_single) begin
            res0    = single;
            res_cnt = 2'd1;
        end
    end

    // Output register and spill stage.
    always_comb begin
        n_out     = r_out;
        n_out_v   = r_out_v & ~pop;
        n_spill   = r_spill;
        n_spill_v = r_spill_v;
        if (r_spill_v) begin
            if (pop) begin
                n_out     = r_spill;
                n_out_v   = 1'b1;
                n_spill_v = 1'b0;
            end
        end else if (accept && res_cnt != 2'd0) begin
            n_out   = res0;
            n_out_v = 1'b1;
            if (res_cnt == 2'd2) begin
                n_spill   = res1;
                n_spill_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= stok_pkg::MODE_IDLE;
            r_text    <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_out_v   <= 1'b0;
            r_spill_v <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_text    <= n_text;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_out_v   <= n_out_v;
            r_spill_v <= n_spill_v;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_spill <= n_spill;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_spill_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spill_v |-> r_out_v)
        else $error("spill stage holds a token while output register is empty");

    a_spill_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spill_v |-> r_spill.last_of_item)
        else $error("second token of a transfer is not flagged last");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("pending length exceeds token capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_MAX))
        else $error("overflow set while pending token is not full");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.op == stok_pkg::OP_END) |=>
            (r_mode == stok_pkg::MODE_IDLE && r_len == '0 && r_out_v))
        else $error("end of source did not clear scanner or emit a token");

endmodule

// ===== verif/source_tokenizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_test - self-checking bench for the source tokenizer
// Streams directed and random source text through the block. A scoreboard
// predicts every token from the accepted bytes and checks the token stream
// field by field, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module source_tokenizer_test;

    localparam int TEXT_W      = stok_pkg::TEXT_W;
    localparam int LEN_W       = stok_pkg::LEN_W;
    localparam int TOKEN_CHARS = stok_pkg::MAX_TOKEN_CHARS_DEF;
    localparam int HALF_PERIOD = 4;
    localparam int ITEM_TARGET = 700;
    localparam int CYCLE_LIMIT = 300_000;
    localparam int TAIL_CYCLES = 12;
    localparam int REPORT_CAP  = 40;

    // ------------------------------------------------------------------------
    // Token scoreboard: tracks the scanner state as the block should see it
    // and keeps the tokens still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class token_ledger;
        stok_pkg::t_token_out due[$];
        stok_pkg::t_scan_mode mode;
        logic [TEXT_W-1:0]    held_text;
        logic [LEN_W-1:0]     held_len;
        bit                   held_over;
        int                   mismatches;
        int                   tokens_checked;
        int                   keywords_seen;
        int                   truncs_seen;
        int                   ends_seen;

        function new();
            clear();
            mismatches     = 0;
            tokens_checked = 0;
            keywords_seen  = 0;
            truncs_seen    = 0;
            ends_seen      = 0;
        endfunction

        function bit letter_char(logic [7:0] c);
            return c inside {["a":"z"], ["A":"Z"]};
        endfunction

        function bit digit_char(logic [7:0] c);
            return c inside {["0":"9"]};
        endfunction

        function bit op_char(logic [7:0] c);
            return c inside {"+", "-", "*", "/"};
        endfunction

        function bit punct_char(logic [7:0] c);
            return c inside {"{", "}", "(", ")", ";"};
        endfunction

        function void clear();
            mode      = stok_pkg::MODE_IDLE;
            held_text = '0;
            held_len  = '0;
            held_over = 1'b0;
        endfunction

        function void push_token(stok_pkg::t_token_kind kind, logic [TEXT_W-1:0] text,
                                 logic [LEN_W-1:0] len, bit trunc, bit last);
            stok_pkg::t_token_out tok;
            tok.token_kind   = kind;
            tok.token_text   = text;
            tok.token_length = len;
            tok.truncated    = trunc;
            tok.last_of_item = last;
            due.insert(due.size(), tok);
        endfunction

        // keep the first characters only, flag the rest
        function void add_char(logic [7:0] c);
            if (held_len < TOKEN_CHARS) begin
                held_text[8*held_len +: 8] = c;
                held_len++;
            end else begin
                held_over = 1'b1;
            end
        endfunction

        // emit the pending word or number, if any, and go idle
        function void flush_held(bit last);
            stok_pkg::t_token_kind kind;
            if (mode == stok_pkg::MODE_IDENT || mode == stok_pkg::MODE_NUMBER) begin
                kind = (mode == stok_pkg::MODE_IDENT) ? stok_pkg::KIND_IDENT
                                                      : stok_pkg::KIND_NUMBER;
                if (kind == stok_pkg::KIND_IDENT && !held_over &&
                    ((held_len == stok_pkg::KW_INT_LEN &&
                      held_text == stok_pkg::KW_INT_TEXT) ||
                     (held_len == stok_pkg::KW_RETURN_LEN &&
                      held_text == stok_pkg::KW_RETURN_TEXT)))
                    kind = stok_pkg::KIND_KEYWORD;
                push_token(kind, held_text, held_len, held_over, last);
            end
            clear();
        endfunction

        function void take_byte(stok_pkg::t_src_in item);
            logic [7:0] c;
            c = item.source_byte;
            if (item.op == stok_pkg::OP_END) begin
                flush_held(1'b0);
                push_token(stok_pkg::KIND_END, '0, '0, 1'b0, 1'b1);
                return;
            end
            if (mode == stok_pkg::MODE_IDENT && (letter_char(c) || digit_char(c))) begin
                add_char(c);
                return;
            end
            if (mode == stok_pkg::MODE_NUMBER && digit_char(c)) begin
                add_char(c);
                return;
            end
            flush_held(!(op_char(c) || punct_char(c)));
            if (letter_char(c)) begin
                mode = stok_pkg::MODE_IDENT;
                add_char(c);
            end else if (digit_char(c)) begin
                mode = stok_pkg::MODE_NUMBER;
                add_char(c);
            end else if (op_char(c)) begin
                push_token(stok_pkg::KIND_OPERATOR, TEXT_W'(c), LEN_W'(1), 1'b0, 1'b1);
            end else if (punct_char(c)) begin
                push_token(stok_pkg::KIND_PUNCT, TEXT_W'(c), LEN_W'(1), 1'b0, 1'b1);
            end
        endfunction

        function void report(string field, logic [TEXT_W-1:0] want,
                             logic [TEXT_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, field, want, got);
        endfunction

        function void match_token(stok_pkg::t_token_out got);
            stok_pkg::t_token_out want;
            if (due.size() == 0) begin
                report("unexpected token", '0, TEXT_W'(got.token_kind));
                return;
            end
            want = due.pop_front();
            tokens_checked++;
            if (want.token_kind == stok_pkg::KIND_KEYWORD) keywords_seen++;
            if (want.token_kind == stok_pkg::KIND_END) ends_seen++;
            if (want.truncated) truncs_seen++;
            if (got.token_kind !== want.token_kind)
                report("token_kind", TEXT_W'(want.token_kind), TEXT_W'(got.token_kind));
            if (got.token_text !== want.token_text)
                report("token_text", want.token_text, got.token_text);
            if (got.token_length !== want.token_length)
                report("token_length", TEXT_W'(want.token_length),
                       TEXT_W'(got.token_length));
            if (got.truncated !== want.truncated)
                report("truncated", TEXT_W'(want.truncated), TEXT_W'(got.truncated));
            if (got.last_of_item !== want.last_of_item)
                report("last_of_item", TEXT_W'(want.last_of_item),
                       TEXT_W'(got.last_of_item));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and bench state
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    stok_pkg::t_src_in    in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    stok_pkg::t_token_out out_data;

    token_ledger ledger;
    bit          calm_src;      // sender transfers back to back while set
    bit          calm_sink;     // receiver never stalls while set
    int          sent_items;
    int          sink_hold = 0;
    int          sink_draw;
    int          cycles = 0;

    always #(HALF_PERIOD) clk = ~clk;

    source_tokenizer #(
        .MAX_TOKEN_CHARS(TOKEN_CHARS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Token side: check each transfer, then draw how long to stall before
    // taking the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            sink_hold <= 0;
        end else if (out_valid && !out_stall) begin
            ledger.match_token(out_data);
            sink_draw = calm_sink ? 0 : $urandom_range(0, 10);
            out_stall <= (sink_draw > 0);
            sink_hold <= (sink_draw > 0) ? sink_draw - 1 : 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d tokens still owed",
                     $time, cycles, ledger.due.size());
            $display("source_tokenizer_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Source side. Valid stays high after a transfer so that back-to-back
    // items never lower and raise it in one step; anything that waits
    // drops it first.
    // ------------------------------------------------------------------------
    task automatic send_item(stok_pkg::t_src_in item);
        int gap;
        gap = calm_src ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        ledger.take_byte(item);
        sent_items++;
    endtask

    task automatic send_byte(logic [7:0] c);
        stok_pkg::t_src_in item;
        item.op          = stok_pkg::OP_BYTE;
        item.source_byte = c;
        send_item(item);
    endtask

    // the byte rides along with end of source but must be ignored
    task automatic send_end();
        stok_pkg::t_src_in item;
        item.op          = stok_pkg::OP_END;
        item.source_byte = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold the sender until every owed token has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (ledger.due.size() > 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                    : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    // anything the scanner skips: controls, space, high half, stray marks
    function automatic logic [7:0] pick_skip();
        string marks;
        marks = "!\"#$%&',.:<=>?@[\\]^_`|~";
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, 31));
            1: return 8'h20;
            2: return 8'($urandom_range(128, 255));
            3: return 8'h7F;
            default: return marks[$urandom_range(0, marks.len() - 1)];
        endcase
    endfunction

    // identifier or number; now and then longer than the token can hold
    task automatic send_run(bit numeric);
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if (numeric)
                send_byte(pick_digit());
            else if (i == 0 || $urandom_range(0, 3) != 0)
                send_byte(pick_letter());
            else
                send_byte(pick_digit());
        end
    endtask

    // keywords and words that only look like them
    task automatic send_keyword_like();
        case ($urandom_range(0, 9))
            0, 1: send_text("int");
            2, 3: send_text("return");
            4: send_text("in");
            5: send_text("intx");
            6: send_text("retur");
            7: send_text("return7");
            8: send_text("Int");
            default: send_text("returnable");
        endcase
    endtask

    task automatic send_operator();
        case ($urandom_range(0, 3))
            0: send_byte("+");
            1: send_byte("-");
            2: send_byte("*");
            default: send_byte("/");
        endcase
    endtask

    task automatic send_punct();
        case ($urandom_range(0, 4))
            0: send_byte("{");
            1: send_byte("}");
            2: send_byte("(");
            3: send_byte(")");
            default: send_byte(";");
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int next_phase;
        int pick;
        bit paused;

        ledger     = new;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        calm_src   = 1'b0;
        calm_sink  = 1'b0;
        sent_items = 0;
        paused     = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: end of source with nothing pending, keyword closed by a
        // punctuator, keyword closed by an opening paren, letters after
        // digits, an identifier closed by an operator, every remaining
        // operator and punctuator, skipped extremes of the byte range, and
        // end of source flushing a pending identifier.
        send_end();
        send_text("int;return(9x+-*/{})");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte("z");
        send_end();

        // Random: mostly well-formed text, some noise. Redraw the pacing of
        // both sides every hundred items so back-to-back stretches appear.
        next_phase = sent_items + 100;
        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= next_phase) begin
                calm_src   = ($urandom_range(0, 2) == 0);
                calm_sink  = ($urandom_range(0, 2) == 0);
                next_phase = sent_items + 100;
            end
            if (!paused && sent_items >= ITEM_TARGET / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_run(1'b0);
                if ($urandom_range(0, 9) < 7) send_byte(pick_skip());
            end else if (pick < 42) begin
                send_run(1'b1);
                if ($urandom_range(0, 9) < 6) send_byte(pick_skip());
            end else if (pick < 52) begin
                send_keyword_like();
                if ($urandom_range(0, 9) < 7) send_byte(" ");
            end else if (pick < 64) begin
                send_operator();
            end else if (pick < 75) begin
                send_punct();
            end else if (pick < 87) begin
                send_byte(pick_skip());
            end else if (pick < 93) begin
                send_end();
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        // close the text so any pending token comes out
        send_end();
        in_valid <= 1'b0;

        while (ledger.due.size() > 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (ledger.due.size() > 0)
            $display("%0t: %0d tokens never arrived", $time, ledger.due.size());
        $display("source_tokenizer_test: %0d source items sent, %0d tokens checked",
                 sent_items, ledger.tokens_checked);
        $display("source_tokenizer_test: %0d keywords, %0d truncated, %0d end tokens",
                 ledger.keywords_seen, ledger.truncs_seen, ledger.ends_seen);
        if (ledger.mismatches == 0 && ledger.due.size() == 0) begin
            $display("source_tokenizer_test: done, clean");
        end else begin
            $display("source_tokenizer_test: done, errors");
        end
        $finish;
    end

endmodule
